@@ design/rdc_pkg.sv @@
// Shared types and constants for the radix digit converter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rdc_pkg;

	// Default sizing of the block.
	localparam int RDC_MAX_DIGITS = 32;
	localparam int RDC_VALUE_BITS = 31;

	// A digit and the base are one byte wide.
	localparam int DIGIT_BITS = 8;

	// Base after reset, and the smallest base that is used.
	localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 8'd10;
	localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 8'd2;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_READ,
		ST_EMIT
	} back_state_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

@@ design/rdc_front.sv @@
// Front end of the radix digit converter: accepts input items, marks zero values
// and holds them in a two-entry queue for the back end. Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_front #(
	parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value, zero padded
	output logic                                q_valid,
	output logic                                q_zero,
	output logic [VALUE_BITS-1:0]               q_value,
	input  logic                                q_pop
);
	import rdc_pkg::*;

	logic [VALUE_BITS-1:0] val_q [2];
	logic                  zero_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  push;
	logic                  pop;
	logic [VALUE_BITS-1:0] in_value;

	// Bits above the value width are ignored.
	assign in_value      = s_axis_tdata[VALUE_BITS-1:0];
	assign s_axis_tready = (fill_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;

	assign q_valid = (fill_q != 2'd0);
	assign q_zero  = zero_q[rd_ptr_q];
	assign q_value = val_q[rd_ptr_q];

	// Queue storage: the zero flag is worked out once, on the way in.
	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_ptr_q]  <= in_value;
			zero_q[wr_ptr_q] <= (in_value == '0);
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

@@ design/rdc_div.sv @@
// Restoring divider of the radix digit converter: one quotient bit per cycle,
// giving the quotient and the remainder of a value by the base. Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_div #(
	parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [VALUE_BITS-1:0]           dividend,
	input  logic [rdc_pkg::DIGIT_BITS-1:0]  divisor,
	output rdc_pkg::div_status_t            status,
	output logic [VALUE_BITS-1:0]           quotient,
	output logic [rdc_pkg::DIGIT_BITS-1:0]  remainder
);
	import rdc_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [DIGIT_BITS-1:0] div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIGIT_BITS:0]   trial;
	logic [DIGIT_BITS:0]   diff;
	logic                  fits;

	// One trial subtraction of the shifted remainder.
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

	// Datapath: the dividend shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
		end
	end

	// Bit counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(VALUE_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A new division never starts over one in progress.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	// A finished remainder is always a valid digit of the base.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

endmodule

@@ design/rdc_back.sv @@
// Back end of the radix digit converter: runs the divisions, keeps the digit
// stack and emits the digits most significant first. Depends on rdc_pkg, rdc_div.
`timescale 1ns / 1ps

module rdc_back #(
	parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS,
	parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rdc_pkg::DIGIT_BITS-1:0]  radix,
	input  logic                            q_valid,
	input  logic                            q_zero,
	input  logic [VALUE_BITS-1:0]           q_value,
	output logic                            q_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rdc_pkg::DIGIT_BITS-1:0]  m_axis_tdata,  // digit
	output logic                            m_axis_tlast   // last_digit
);
	import rdc_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	back_state_t           state_q;
	back_state_t           state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      cnt_dec;
	logic [VALUE_BITS-1:0] rest_q;
	logic [DIGIT_BITS-1:0] base;
	logic [DIGIT_BITS-1:0] stack_mem [MAX_DIGITS];
	logic [DIGIT_BITS-1:0] rd_data_q;
	logic [DIGIT_BITS-1:0] digit_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  div_start;
	div_status_t           div_status;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DIGIT_BITS-1:0] div_rem;
	logic                  load_zero;
	logic                  load_rest;
	logic                  store_digit;
	logic                  read_digit;
	logic                  load_out;

	// A base of zero or one is taken as two.
	assign base = (radix < RADIX_MIN) ? RADIX_MIN : radix;

	assign cnt_inc  = cnt_q + 1'b1;
	assign cnt_dec  = cnt_q - 1'b1;
	assign out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = digit_q;
	assign m_axis_tlast  = last_q;

	rdc_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rest_q),
		.divisor   (base),
		.status    (div_status),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		div_start   = 1'b0;
		load_zero   = 1'b0;
		load_rest   = 1'b0;
		store_digit = 1'b0;
		read_digit  = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_zero) begin
						load_zero = 1'b1;
						state_d   = ST_READ;
					end else begin
						load_rest = 1'b1;
						state_d   = ST_START;
					end
				end
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_status.done) begin
					store_digit = 1'b1;
					if (div_quo == '0 || cnt_inc == CNT_W'(MAX_DIGITS)) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_START;
					end
				end
			end
			ST_READ: begin
				read_digit = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = (cnt_q == '0) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Digit stack: pushed at the fill level, popped from the top.
	always_ff @(posedge clk) begin
		if (load_zero) begin
			stack_mem[0] <= '0;
		end else if (store_digit) begin
			stack_mem[cnt_q[IDX_W-1:0]] <= div_rem;
		end
		if (read_digit) begin
			rd_data_q <= stack_mem[cnt_dec[IDX_W-1:0]];
		end
	end

	// Remaining quotient carried between divisions.
	always_ff @(posedge clk) begin
		if (load_rest) begin
			rest_q <= q_value;
		end else if (store_digit) begin
			rest_q <= div_quo;
		end
	end

	// Stack fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_zero) begin
			cnt_q <= CNT_W'(1);
		end else if (store_digit) begin
			cnt_q <= cnt_inc;
		end else if (read_digit) begin
			cnt_q <= cnt_dec;
		end
	end

	// Output register: holds a digit until the sink takes it.
	always_ff @(posedge clk) begin
		if (load_out) begin
			digit_q <= rd_data_q;
			last_q  <= (cnt_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The stack never holds more digits than it has room for.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit stack overfilled");

	// The final digit of a run leaves the stack empty and the sequencer idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && cnt_q == '0) |=> (state_q == ST_IDLE && cnt_q == '0))
		else $error("run ended with digits left");

	// The divider only runs while the sequencer waits for its result.
	a_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.busy |-> (state_q == ST_WAIT))
		else $error("divider busy outside the wait state");

endmodule

@@ design/radix_digit_converter.sv @@
// Radix digit converter: converts each input value to its digits in the base held
// in the radix register, most significant digit first, and flags the final digit
// with tlast. A zero value gives the single digit 0; a base below two counts as two.
// Items are taken into a two-entry queue while earlier items are converted. Every
// digit costs one pass over all VALUE_BITS bits of the shared one-bit-per-cycle
// divider, with ST_START to start it and ST_WAIT to store the remainder, then
// ST_READ and ST_EMIT to pop and emit it; the sink holding off delays a waiting
// digit. With the default 31-bit value the largest value has ten digits in base
// ten, and up to 31 digits in base two. A zero value skips the divider.
// Depends on rdc_pkg, rdc_front and rdc_back.
`timescale 1ns / 1ps

module radix_digit_converter #(
	parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS,
	parameter int VALUE_BITS = rdc_pkg::RDC_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rdc_pkg::DIGIT_BITS-1:0]  cfg_wdata,      // radix
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,   // value, zero padded
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rdc_pkg::DIGIT_BITS-1:0]  m_axis_tdata,   // digit
	output logic                            m_axis_tlast    // last_digit
);
	import rdc_pkg::*;

	logic [DIGIT_BITS-1:0] radix_q;
	logic                  q_valid;
	logic                  q_zero;
	logic [VALUE_BITS-1:0] q_value;
	logic                  q_pop;

	// Base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	rdc_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_valid       (q_valid),
		.q_zero        (q_zero),
		.q_value       (q_value),
		.q_pop         (q_pop)
	);

	rdc_back #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.radix         (radix_q),
		.q_valid       (q_valid),
		.q_zero        (q_zero),
		.q_value       (q_value),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
